>>> rtl/drm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_pkg
// Shared types and constants of the decimated running mean/variance block.
// ============================================================================
package drm_pkg;

    localparam int COL_W      = 4;
    localparam int SAMPLE_W   = 32;
    localparam int VAR_W      = 48;
    localparam int COUNT_W    = 32;
    localparam int DEC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // divider operand widths: numerator left aligned, denominator up to 2^32
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_ITER_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_RECORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION   = 2'd1;

    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [COL_W-1:0]           column;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]           out_column;
        logic signed [SAMPLE_W-1:0] mean;
        logic [VAR_W-1:0]           variance;
        logic                       folded;
        logic [COUNT_W-1:0]         used_records;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic rd;        // read the column statistics
        logic eval;      // decide, latch old statistics, advance record counters
        logic seed;      // first folded record: mean = sample, variance = 0
        logic div_mean;  // start mean step division
        logic mean_upd;  // apply rounded mean step
        logic abs_err;   // |sample - new mean|
        logic mul;       // error product
        logic tsum;      // rounded scaling of the product
        logic div_var;   // start variance step division
        logic var_upd;   // apply variance step, saturate, write back
        logic emit;      // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fold_now;  // current item is in range and its record is used
        logic cnt_zero;  // no record folded before this one
        logic folded;    // latched fold decision of the current item
        logic div_busy;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> rtl/drm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_stream_if
// Valid/ready stream channel with a typed payload.
// ============================================================================
interface drm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/decimated_running_mean_variance.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// decimated_running_mean_variance
// Per-column running mean and unbiased variance over decimated records.
// ============================================================================
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  i_in     | in  | valid/ready        | column, sample
//  o_out    | out | valid/ready        | out_column, mean, variance, folded,
//           |     |                    | used_records
//  i_cfg_*  | in  | write enable only  | register index, write data
//
//  A skipped, undecimated or out-of-range sample, and the first folded
//  record, go from the decision straight to the output register. A
//  folded sample passes twice through the radix-2 divider that serves the
//  mean step and then the variance step one quotient bit a cycle.
//  One transaction is in work at a time; the next one is taken while the
//  previous result waits in the output register. A stalled output holds the
//  sequencer in its last step. Reset clears counters and handshakes; the
//  column store is not cleared.
// ============================================================================
module decimated_running_mean_variance #(
    parameter int COLUMNS   = 10,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [drm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    drm_stream_if.sink                          i_in,
    drm_stream_if.source                        o_out
);
    import drm_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    t_out_item w_out_item;
    logic      w_in_ready;
    logic      w_out_valid;

    drm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    drm_dp #(
        .COLUMNS   (COLUMNS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.data),
        .o_item     (w_out_item)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a transaction is in work");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_mean || w_cmd.div_var) |-> !w_sts.div_busy)
        else $error("divider started while busy");

    a_write_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.var_upd |-> w_sts.folded)
        else $error("statistics written for a sample that is not folded");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out.valid)
        else $error("result loaded but not presented");

    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && ({1'b0, o_out.data.out_column} >= (COL_W + 1)'(COLUMNS)))
        |-> (o_out.data.mean == '0 && o_out.data.variance == '0 && !o_out.data.folded))
        else $error("out-of-range column answered with statistics");
endmodule
`default_nettype wire

>>> rtl/drm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module drm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 10
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/drm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_div
// Radix-2 restoring divider, one quotient bit a cycle, rounded to nearest
// with ties up. The numerator arrives left aligned with its bit count.
// ============================================================================
module drm_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [drm_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [drm_pkg::DIV_DEN_W-1:0]  i_den,
    input  wire logic [drm_pkg::DIV_ITER_W-1:0] i_iters,
    output logic                                o_busy,
    output logic                                o_done,
    output logic      [drm_pkg::DIV_NUM_W-1:0]  o_quot
);
    import drm_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_RND  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [DIV_ITER_W-1:0] r_left;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [DIV_NUM_W-1:0]  r_quot;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W-1:0]  r_rem;

    logic [DIV_DEN_W:0] w_rem_sh;
    logic [DIV_DEN_W:0] w_rem_sub;
    logic               w_ge;
    logic               w_inc;

    assign w_rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    // round up when twice the remainder reaches the divisor
    assign w_inc     = {r_rem, 1'b0} >= {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_RUN;
            D_RUN:  if (r_left == DIV_ITER_W'(1)) n_state = D_RND;
            D_RND:  n_state = D_DONE;
            D_DONE: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_left <= i_iters;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_state == D_RUN) begin
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
            r_quot <= {r_quot[DIV_NUM_W-2:0], w_ge};
            r_left <= r_left - DIV_ITER_W'(1);
        end else if (r_state == D_RND) begin
            r_quot <= r_quot + DIV_NUM_W'(w_inc);
        end
    end

    assign o_busy = r_state != D_IDLE;
    assign o_done = r_state == D_DONE;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> rtl/drm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_dp
// Datapath: record counters, column statistics store, shared divider,
// error multiplier and the output register.
// ============================================================================
module drm_dp #(
    parameter int COLUMNS   = 10,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire drm_pkg::t_dp_cmd                i_cmd,
    output drm_pkg::t_dp_sts                     o_sts,
    input  wire logic                            i_cfg_we,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [drm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire drm_pkg::t_in_item               i_item,
    output drm_pkg::t_out_item                   o_item
);
    import drm_pkg::*;

    localparam int AW     = COLUMNS > 1 ? $clog2(COLUMNS) : 1;
    localparam int MEM_W  = SAMPLE_W + VAR_W;
    localparam int TW     = DIV_NUM_W - FRAC_BITS;
    localparam int DIFF_W = TW > VAR_W ? TW : VAR_W;
    localparam logic [DIV_NUM_W-1:0] HALF = (DIV_NUM_W'(1) << FRAC_BITS) >> 1;
    localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // record counters
    logic [COUNT_W-1:0] r_skip_left;
    logic [DEC_W-1:0]   r_decim;
    logic [DEC_W-1:0]   r_phase;
    logic [COUNT_W-1:0] r_record_count;

    // item payload
    logic [COL_W-1:0]     r_col;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [COUNT_W-1:0]   r_cnt;
    logic [SAMPLE_W-1:0]  r_old_mean;
    logic [VAR_W-1:0]     r_old_var;
    logic                 r_neg;
    logic [SAMPLE_W-1:0]  r_mag;
    logic [SAMPLE_W-1:0]  r_new_mean;
    logic [SAMPLE_W-1:0]  r_abs_err;
    logic [DIV_NUM_W-1:0] r_prod;
    logic [DIV_NUM_W-1:0] r_t;
    logic                 r_var_neg;
    logic                 r_fold;
    logic [SAMPLE_W-1:0]  r_res_mean;
    logic [VAR_W-1:0]     r_res_var;
    t_out_item            r_out;

    logic w_in_range, w_close, w_skipping, w_use;
    logic [DEC_W-1:0] w_dec;
    logic [DEC_W:0]   w_phase_nx;
    logic [DEC_W-1:0] w_phase_new;

    logic [MEM_W-1:0]    w_rdata;
    logic [SAMPLE_W-1:0] w_rd_mean;
    logic [VAR_W-1:0]    w_rd_var;
    logic                w_mem_we;
    logic [MEM_W-1:0]    w_wdata;

    logic [SAMPLE_W:0]   w_d;
    logic [SAMPLE_W:0]   w_d_abs;
    logic [SAMPLE_W:0]   w_nm;
    logic [SAMPLE_W:0]   w_e;
    logic [SAMPLE_W:0]   w_e_abs;
    logic [DIV_NUM_W-1:0] w_tsum;
    logic [DIV_NUM_W-1:0] w_var64;
    logic                 w_t_lt;
    logic [DIV_NUM_W-1:0] w_diff;
    logic [DIV_NUM_W-1:0] w_vsum;
    logic [VAR_W-1:0]     w_vsat;

    logic                  w_div_start;
    logic [DIV_NUM_W-1:0]  w_div_num;
    logic [DIV_DEN_W-1:0]  w_div_den;
    logic [DIV_ITER_W-1:0] w_div_iters;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_quot;

    // record decision
    assign w_in_range  = {1'b0, r_col} < COL_LIMIT;
    assign w_close     = r_col == COL_LAST;
    assign w_skipping  = r_skip_left != '0;
    assign w_use       = !w_skipping && (r_phase == '0);
    assign w_dec       = (r_decim == '0) ? DEC_W'(1) : r_decim;
    assign w_phase_nx  = {1'b0, r_phase} + (DEC_W + 1)'(1);
    assign w_phase_new = (w_phase_nx >= {1'b0, w_dec}) ? '0 : w_phase_nx[DEC_W-1:0];

    assign w_rd_mean = w_rdata[VAR_W +: SAMPLE_W];
    assign w_rd_var  = w_rdata[VAR_W-1:0];

    // mean step operands
    assign w_d     = {r_sample[SAMPLE_W-1], r_sample} - {w_rd_mean[SAMPLE_W-1], w_rd_mean};
    assign w_d_abs = w_d[SAMPLE_W] ? ((SAMPLE_W + 1)'(0) - w_d) : w_d;
    assign w_nm    = r_neg ? ({r_old_mean[SAMPLE_W-1], r_old_mean} - {1'b0, w_quot[SAMPLE_W-1:0]})
                           : ({r_old_mean[SAMPLE_W-1], r_old_mean} + {1'b0, w_quot[SAMPLE_W-1:0]});
    assign w_e     = {r_sample[SAMPLE_W-1], r_sample} - {r_new_mean[SAMPLE_W-1], r_new_mean};
    assign w_e_abs = w_e[SAMPLE_W] ? ((SAMPLE_W + 1)'(0) - w_e) : w_e;

    // variance step operands
    assign w_tsum  = r_prod + HALF;
    assign w_var64 = DIV_NUM_W'(r_old_var);
    assign w_t_lt  = r_t < w_var64;
    assign w_diff  = w_t_lt ? (w_var64 - r_t) : (r_t - w_var64);
    assign w_vsum  = r_var_neg ? (w_var64 - w_quot) : (w_var64 + w_quot);
    assign w_vsat  = (w_vsum[DIV_NUM_W-1:VAR_W] != '0) ? VAR_MAX : w_vsum[VAR_W-1:0];

    // divider operand select
    assign w_div_start = i_cmd.div_mean || i_cmd.div_var;
    always_comb begin
        if (i_cmd.div_var) begin
            w_div_num   = w_diff << (DIV_NUM_W - DIFF_W);
            w_div_den   = {1'b0, r_cnt};
            w_div_iters = DIV_ITER_W'(DIFF_W);
        end else begin
            w_div_num   = {w_d_abs[SAMPLE_W-1:0], {(DIV_NUM_W - SAMPLE_W){1'b0}}};
            w_div_den   = {1'b0, r_cnt} + DIV_DEN_W'(1);
            w_div_iters = DIV_ITER_W'(SAMPLE_W);
        end
    end

    assign w_mem_we = i_cmd.seed || i_cmd.var_upd;
    assign w_wdata  = i_cmd.seed ? {r_sample, {VAR_W{1'b0}}} : {r_new_mean, w_vsat};

    drm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (COLUMNS)
    ) u_stats (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_col[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (w_rdata)
    );

    drm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_iters (w_div_iters),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left    <= '0;
            r_decim        <= DEC_W'(1);
            r_phase        <= '0;
            r_record_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SKIP_RECORDS: r_skip_left <= i_cfg_data;
                CFG_DECIMATION:   r_decim     <= i_cfg_data[DEC_W-1:0];
                default: ;
            endcase
        end else if (i_cmd.eval && w_in_range && w_close) begin
            if (w_skipping) begin
                r_skip_left <= r_skip_left - COUNT_W'(1);
            end else begin
                r_phase <= w_phase_new;
                if (w_use && r_record_count != COUNT_MAX) begin
                    r_record_count <= r_record_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col    <= i_item.column;
            r_sample <= i_item.sample;
            r_cnt    <= r_record_count;
        end
        if (i_cmd.eval) begin
            r_old_mean <= w_rd_mean;
            r_old_var  <= w_rd_var;
            r_neg      <= w_d[SAMPLE_W];
            r_mag      <= w_d_abs[SAMPLE_W-1:0];
            r_fold     <= w_in_range && w_use;
            // a seeded column answers its own sample with zero variance
            r_res_mean <= i_cmd.seed ? r_sample : (w_in_range ? w_rd_mean : '0);
            r_res_var  <= (w_in_range && !i_cmd.seed) ? w_rd_var : '0;
        end
        if (i_cmd.mean_upd) begin
            r_new_mean <= w_nm[SAMPLE_W-1:0];
            r_res_mean <= w_nm[SAMPLE_W-1:0];
        end
        if (i_cmd.abs_err) begin
            r_abs_err <= w_e_abs[SAMPLE_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= r_abs_err * r_mag;
        end
        if (i_cmd.tsum) begin
            r_t <= w_tsum >> FRAC_BITS;
        end
        if (i_cmd.div_var) begin
            r_var_neg <= w_t_lt;
        end
        if (i_cmd.var_upd) begin
            r_res_var <= w_vsat;
        end
        if (i_cmd.emit) begin
            r_out.out_column   <= r_col;
            r_out.mean         <= r_res_mean;
            r_out.variance     <= r_res_var;
            r_out.folded       <= r_fold;
            r_out.used_records <= r_record_count;
        end
    end

    assign o_sts.fold_now = w_in_range && w_use;
    assign o_sts.cnt_zero = r_cnt == '0;
    assign o_sts.folded   = r_fold;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_item         = r_out;
endmodule
`default_nettype wire

>>> rtl/drm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// drm_ctrl
// Sequencer: walks one transaction through read, decision, the two
// divisions and write-back, and owns both handshakes.
// ============================================================================
module drm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire drm_pkg::t_dp_sts i_sts,
    output drm_pkg::t_dp_cmd      o_cmd
);
    import drm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_READ     = 4'd1;
    localparam logic [3:0] S_EVAL     = 4'd2;
    localparam logic [3:0] S_DIV_MEAN = 4'd3;
    localparam logic [3:0] S_ABS_ERR  = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_TSUM     = 4'd6;
    localparam logic [3:0] S_DIFF     = 4'd7;
    localparam logic [3:0] S_DIV_VAR  = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                w_cmd.eval = 1'b1;
                if (i_sts.fold_now && !i_sts.cnt_zero) begin
                    w_cmd.div_mean = 1'b1;
                    n_state        = S_DIV_MEAN;
                end else begin
                    w_cmd.seed = i_sts.fold_now;
                    n_state    = S_EMIT;
                end
            end
            S_DIV_MEAN: begin
                if (i_sts.div_done) begin
                    w_cmd.mean_upd = 1'b1;
                    n_state        = S_ABS_ERR;
                end
            end
            S_ABS_ERR: begin
                w_cmd.abs_err = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_TSUM;
            end
            S_TSUM: begin
                w_cmd.tsum = 1'b1;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                w_cmd.div_var = 1'b1;
                n_state       = S_DIV_VAR;
            end
            S_DIV_VAR: begin
                if (i_sts.div_done) begin
                    w_cmd.var_upd = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;
endmodule
`default_nettype wire
